// ===== rtl/ptrmx_pkg.sv =====
// Shared constants and codes for the persistent trie range max-XOR unit.
package ptrmx_pkg;

	// Default sizing of the trie.
	localparam int MAX_ELEMENTS_DEF = 4096;
	localparam int KEY_BITS_DEF     = 16;

	// Request operation codes.
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Result status codes.
	localparam int          STATUS_W  = 2;
	localparam logic [1:0]  ST_OK     = 2'd0;
	localparam logic [1:0]  ST_RANGE  = 2'd1;
	localparam logic [1:0]  ST_FULL   = 2'd2;

endpackage

// ===== rtl/ptrmx_pool.sv =====
// Node pool memory: one write port, two registered read ports, node zero reads as null.
module ptrmx_pool import ptrmx_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int KEY_BITS     = KEY_BITS_DEF,
	localparam int POOL_NODES  = MAX_ELEMENTS * (KEY_BITS + 1) + 1,
	localparam int POS_W       = $clog2(MAX_ELEMENTS + 1),
	localparam int NODE_W      = $clog2(POOL_NODES),
	localparam int ENT_W       = POS_W + 2 * NODE_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [NODE_W-1:0] wr_addr,
	input  logic [ENT_W-1:0]  wr_data,
	input  logic [NODE_W-1:0] rd_addr_a,
	input  logic [NODE_W-1:0] rd_addr_b,
	output logic [ENT_W-1:0]  rd_data_a,
	output logic [ENT_W-1:0]  rd_data_b
);

	logic [ENT_W-1:0] mem [POOL_NODES];
	logic [ENT_W-1:0] raw_a_q;
	logic [ENT_W-1:0] raw_b_q;
	logic             null_a_q;
	logic             null_b_q;

	// Memory array with registered reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		raw_a_q <= mem[rd_addr_a];
		raw_b_q <= mem[rd_addr_b];
	end

	// Node zero is never written; remember which reads hit it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			null_a_q <= 1'b1;
			null_b_q <= 1'b1;
		end else begin
			null_a_q <= (rd_addr_a == '0);
			null_b_q <= (rd_addr_b == '0);
		end
	end

	// The null node has no children and stamp zero.
	assign rd_data_a = null_a_q ? '0 : raw_a_q;
	assign rd_data_b = null_b_q ? '0 : raw_b_q;

endmodule

// ===== rtl/ptrmx_walk.sv =====
// Sequencer that builds trie versions and walks them one level per cycle.
module ptrmx_walk import ptrmx_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int KEY_BITS     = KEY_BITS_DEF,
	localparam int POOL_NODES  = MAX_ELEMENTS * (KEY_BITS + 1) + 1,
	localparam int POS_W       = $clog2(MAX_ELEMENTS + 1),
	localparam int NODE_W      = $clog2(POOL_NODES),
	localparam int ENT_W       = POS_W + 2 * NODE_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                start_op,
	input  logic [KEY_BITS-1:0] start_key,
	input  logic [POS_W-1:0]    start_low,
	input  logic [POS_W-1:0]    start_high,
	output logic                idle,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [KEY_BITS-1:0] res_best,
	output logic [1:0]          res_status,
	output logic                wr_en,
	output logic [NODE_W-1:0]   wr_addr,
	output logic [ENT_W-1:0]    wr_data,
	output logic [NODE_W-1:0]   rd_addr_a,
	output logic [NODE_W-1:0]   rd_addr_b,
	input  logic [ENT_W-1:0]    rd_data_a,
	input  logic [ENT_W-1:0]    rd_data_b
);

	localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_QROOT = 4'd1;
	localparam logic [3:0] S_QREAD = 4'd2;
	localparam logic [3:0] S_QKIDS = 4'd3;
	localparam logic [3:0] S_QWALK = 4'd4;
	localparam logic [3:0] S_AREAD = 4'd5;
	localparam logic [3:0] S_AWALK = 4'd6;
	localparam logic [3:0] S_ALEAF = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]          state_q;
	logic [KEY_BITS-1:0] key_q;
	logic [POS_W-1:0]    low_q;
	logic [POS_W-1:0]    high_q;
	logic [POS_W-1:0]    count_q;
	logic [POS_W-1:0]    pos_q;
	logic [NODE_W-1:0]   used_q;
	logic [NODE_W-1:0]   cur_q;
	logic [NODE_W-1:0]   root_q;
	logic [LVL_W-1:0]    level_q;
	logic [KEY_BITS-1:0] best_q;
	logic [1:0]          status_q;

	logic                key_bit;
	logic [ENT_W-1:0]    flip_ent;
	logic [ENT_W-1:0]    same_ent;
	logic                take_flip;
	logic                take_same;
	logic [ENT_W-1:0]    chosen_ent;
	logic [NODE_W-1:0]   fresh_node;
	logic                query_bad;

	// Decision logic for one level of a walk.
	always_comb begin
		key_bit    = key_q[level_q];
		flip_ent   = key_bit ? rd_data_a : rd_data_b;
		same_ent   = key_bit ? rd_data_b : rd_data_a;
		take_flip  = (flip_ent[ENT_W-1:2*NODE_W] >= low_q);
		take_same  = (same_ent[ENT_W-1:2*NODE_W] >= low_q);
		chosen_ent = take_flip ? flip_ent : same_ent;
		fresh_node = cur_q + NODE_W'(1);
		query_bad  = (start_low == '0) || (start_high == '0) ||
			(start_low > start_high) || (start_high > count_q);
	end

	// Memory port drive for each sequencer step.
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = cur_q;
		wr_data   = '0;
		rd_addr_a = '0;
		rd_addr_b = '0;
		unique case (state_q)
			S_QREAD: begin
				rd_addr_a = root_q;
			end
			S_QKIDS: begin
				rd_addr_a = rd_data_a[NODE_W-1:0];
				rd_addr_b = rd_data_a[2*NODE_W-1:NODE_W];
			end
			S_QWALK: begin
				rd_addr_a = chosen_ent[NODE_W-1:0];
				rd_addr_b = chosen_ent[2*NODE_W-1:NODE_W];
			end
			S_AREAD: begin
				rd_addr_a = (count_q == '0) ? '0 : used_q - NODE_W'(KEY_BITS);
			end
			S_AWALK: begin
				// Copy the old node, replacing the child on the key's side.
				wr_en     = 1'b1;
				wr_data   = {pos_q,
					key_bit ? fresh_node : rd_data_a[2*NODE_W-1:NODE_W],
					key_bit ? rd_data_a[NODE_W-1:0] : fresh_node};
				rd_addr_a = key_bit ? rd_data_a[2*NODE_W-1:NODE_W] : rd_data_a[NODE_W-1:0];
			end
			S_ALEAF: begin
				wr_en   = 1'b1;
				wr_data = {pos_q, {(2*NODE_W){1'b0}}};
			end
			default: begin
			end
		endcase
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			used_q   <= '0;
			key_q    <= '0;
			low_q    <= '0;
			high_q   <= '0;
			pos_q    <= '0;
			cur_q    <= '0;
			root_q   <= '0;
			level_q  <= '0;
			best_q   <= '0;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q    <= start_key;
						low_q    <= start_low;
						high_q   <= start_high;
						best_q   <= '0;
						status_q <= ST_OK;
						level_q  <= LVL_W'(KEY_BITS - 1);
						if (start_op == OP_APPEND) begin
							if (count_q >= POS_W'(MAX_ELEMENTS)) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_AREAD;
							end
						end else begin
							if (query_bad) begin
								status_q <= ST_RANGE;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_QROOT;
							end
						end
					end
				end
				S_QROOT: begin
					// Version p starts at node (p - 1) * (KEY_BITS + 1) + 1.
					root_q  <= (NODE_W'(high_q) - NODE_W'(1)) * NODE_W'(KEY_BITS + 1)
						+ NODE_W'(1);
					state_q <= S_QREAD;
				end
				S_QREAD: begin
					state_q <= S_QKIDS;
				end
				S_QKIDS: begin
					state_q <= S_QWALK;
				end
				S_QWALK: begin
					if (take_flip) begin
						best_q[level_q] <= 1'b1;
					end
					if ((!take_flip && !take_same) || level_q == '0) begin
						state_q <= S_DONE;
					end else begin
						level_q <= level_q - LVL_W'(1);
					end
				end
				S_AREAD: begin
					cur_q   <= used_q + NODE_W'(1);
					pos_q   <= count_q + POS_W'(1);
					state_q <= S_AWALK;
				end
				S_AWALK: begin
					cur_q <= fresh_node;
					if (level_q == '0) begin
						state_q <= S_ALEAF;
					end else begin
						level_q <= level_q - LVL_W'(1);
					end
				end
				S_ALEAF: begin
					used_q  <= cur_q;
					count_q <= pos_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle       = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res_best   = best_q;
	assign res_status = status_q;

`ifndef SYNTHESIS
	// The pool fill always equals one root plus one node per key bit for each stored key.
	a_used_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		used_q == NODE_W'(count_q) * NODE_W'(KEY_BITS + 1))
		else $error("node count out of step with element count");

	// A finished append stores exactly one more key.
	a_append_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALEAF) |=> (count_q == $past(count_q) + POS_W'(1)))
		else $error("append did not advance the element count");

	// A full rejection is only reported with the store at capacity.
	a_full_only_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status == ST_FULL) |-> (count_q == POS_W'(MAX_ELEMENTS)))
		else $error("full status with free capacity");

	// Appends never write node zero or past the end of the pool.
	a_write_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_addr != '0 && int'(wr_addr) < POOL_NODES))
		else $error("pool write outside allocated range");
`endif

endmodule

// ===== rtl/persistent_trie_range_max_xor_unit.sv =====
// Top level of the persistent trie range max-XOR unit with its result register.
//
// Usage: one request channel (operation, key, range_low, range_high) and one
// result channel (best_xor, status), both valid/ready. An append stores key as
// the next position and answers 0 with status ok, or status full when
// MAX_ELEMENTS keys are already stored. A query answers the largest XOR of key
// with any key stored at positions range_low..range_high, or status range when
// that range is empty, names position zero or reaches past the stored count.
// An append walks from the newest root, copying one node per trie level and
// then writing a leaf; a query walks down from the root of version range_high
// and stops early if the walk hits a dead end; a rejected request skips the walk.
// The node pool is read one trie level per cycle.
// The unit takes one request at a time; in_ready is low while it works.
// Reset clears the stored count, so the block starts empty; the pool needs no
// clearing pass. A stalled receiver holds the result in the output register;
// the next request is still taken and runs up to its result, then waits.
module persistent_trie_range_max_xor_unit import ptrmx_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int KEY_BITS     = KEY_BITS_DEF,
	localparam int POOL_NODES  = MAX_ELEMENTS * (KEY_BITS + 1) + 1,
	localparam int POS_W       = $clog2(MAX_ELEMENTS + 1),
	localparam int NODE_W      = $clog2(POOL_NODES),
	localparam int ENT_W       = POS_W + 2 * NODE_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic [KEY_BITS-1:0] key,
	input  logic [POS_W-1:0]    range_low,
	input  logic [POS_W-1:0]    range_high,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [KEY_BITS-1:0] best_xor,
	output logic [1:0]          status
);

	logic                idle;
	logic                res_valid;
	logic                res_ready;
	logic [KEY_BITS-1:0] res_best;
	logic [1:0]          res_status;
	logic                wr_en;
	logic [NODE_W-1:0]   wr_addr;
	logic [ENT_W-1:0]    wr_data;
	logic [NODE_W-1:0]   rd_addr_a;
	logic [NODE_W-1:0]   rd_addr_b;
	logic [ENT_W-1:0]    rd_data_a;
	logic [ENT_W-1:0]    rd_data_b;
	logic                out_valid_q;
	logic [KEY_BITS-1:0] best_q;
	logic [1:0]          status_q;

	assign in_ready = idle;

	ptrmx_walk #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.KEY_BITS    (KEY_BITS)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_valid && idle),
		.start_op   (operation),
		.start_key  (key),
		.start_low  (range_low),
		.start_high (range_high),
		.idle       (idle),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_best   (res_best),
		.res_status (res_status),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr_a  (rd_addr_a),
		.rd_addr_b  (rd_addr_b),
		.rd_data_a  (rd_data_a),
		.rd_data_b  (rd_data_b)
	);

	ptrmx_pool #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.KEY_BITS    (KEY_BITS)
	) u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// Output register: loads a finished result whenever it is empty or being drained.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			best_q   <= res_best;
			status_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign best_xor  = best_q;
	assign status    = status_q;

endmodule
